FILE: design/csd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// csd_pkg: shared types and step functions
// Formats and the per-stage square-root and division steps.
// ---------------------------------------------------------------------------
package csd_pkg;

  localparam int SQ_STEPS  = 65;  // one root bit per stage (130-bit radicand)
  localparam int DIV_STEPS = 33;  // one quotient bit per stage

  typedef enum logic [2:0] {
    REG_XX   = 3'd0,
    REG_XY   = 3'd1,
    REG_XW   = 3'd2,
    REG_YY   = 3'd3,
    REG_YW   = 3'd4,
    REG_WW   = 3'd5,
    REG_MODE = 3'd6
  } reg_idx_t;

  typedef logic signed [47:0] coef_t;
  typedef logic signed [15:0] coord_t;
  typedef logic signed [31:0] dist_t;

  // square-root pipeline payload
  typedef struct packed {
    logic [129:0] s;     // radicand bits not yet consumed, msb first
    logic [67:0]  rem;
    logic [64:0]  root;
  } sq_t;

  // division pipeline payload
  typedef struct packed {
    logic [32:0] mb;     // dividend bits not yet consumed, msb first
    logic [63:0] rem;
    logic [32:0] q;
  } dv_t;

  function automatic sq_t sq_step(input sq_t a);
    sq_t         r;
    logic [67:0] r2;
    logic [67:0] trial;
    r2    = {a.rem[65:0], a.s[129:128]};
    trial = {1'b0, a.root, 2'b01};
    r.s   = {a.s[127:0], 2'b00};
    if (r2 >= trial) begin
      r.rem  = r2 - trial;
      r.root = {a.root[63:0], 1'b1};
    end else begin
      r.rem  = r2;
      r.root = {a.root[63:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(input dv_t a, input logic [63:0] den);
    dv_t         r;
    logic [64:0] t;
    t    = {a.rem, a.mb[32]};
    r.mb = {a.mb[31:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = 64'(t - {1'b0, den});
      r.q   = {a.q[31:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.q   = {a.q[31:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/csd_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// csd channel interfaces
// Point input channel and distance result channel, valid/ready.
// ---------------------------------------------------------------------------
interface csd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface csd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] distance;
  logic               saturated;
  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface
`default_nettype wire

FILE: design/conic_sampson_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// Structure: 5 arithmetic stages, 65 square-root stages, 1 setup stage,
//   33 divide stages and 1 output register, from input accept to result valid.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken.
// Reset: rst_n (synchronous, active low) clears all stage valid bits and the
//   conic registers (all zero, magnitude mode).
// ---------------------------------------------------------------------------
// conic_sampson_distance
// Sampson distance of a point to a symmetric conic, fully pipelined.
// ---------------------------------------------------------------------------
module conic_sampson_distance (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  csd_in_if.sink           in_ch,
  csd_out_if.source        out_ch
);
  import csd_pkg::*;

  // ---------------- configuration registers --------------------------------
  coef_t    xx_r, xy_r, xw_r, yy_r, yw_r, ww_r;
  logic     mode_r;
  reg_idx_t widx;
  logic     cfg_wr;

  assign widx       = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xx_r <= '0; xy_r <= '0; xw_r <= '0;
      yy_r <= '0; yw_r <= '0; ww_r <= '0;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (widx)
        REG_XX:   xx_r   <= cfg_pwdata[47:0];
        REG_XY:   xy_r   <= cfg_pwdata[47:0];
        REG_XW:   xw_r   <= cfg_pwdata[47:0];
        REG_YY:   yy_r   <= cfg_pwdata[47:0];
        REG_YW:   yw_r   <= cfg_pwdata[47:0];
        REG_WW:   ww_r   <= cfg_pwdata[47:0];
        REG_MODE: mode_r <= cfg_pwdata[0];
        default:  ;  // unknown index: ignored
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_XX:   cfg_prdata = {16'd0, xx_r};
      REG_XY:   cfg_prdata = {16'd0, xy_r};
      REG_XW:   cfg_prdata = {16'd0, xw_r};
      REG_YY:   cfg_prdata = {16'd0, yy_r};
      REG_YW:   cfg_prdata = {16'd0, yw_r};
      REG_WW:   cfg_prdata = {16'd0, ww_r};
      REG_MODE: cfg_prdata = {63'd0, mode_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ---------------------------------------
  // Every stage moves when the output register is free or being drained.
  logic out_valid_r;
  logic en;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 1: coefficient x coordinate products -------------
  logic                v1_r;
  logic signed [63:0]  p0a_r, p0b_r, p1a_r, p1b_r, p2a_r, p2b_r;
  coord_t              x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0a_r <= xx_r * in_ch.point_x;
      p0b_r <= xy_r * in_ch.point_y;
      p1a_r <= xy_r * in_ch.point_x;
      p1b_r <= yy_r * in_ch.point_y;
      p2a_r <= xw_r * in_ch.point_x;
      p2b_r <= yw_r * in_ch.point_y;
      x1_r  <= in_ch.point_x;
      y1_r  <= in_ch.point_y;
    end
  end

  // ---------------- stage 2: gradient G = K P ------------------------------
  logic               v2_r;
  logic signed [65:0] g0_r, g1_r, g2_r;
  coord_t             x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g0_r <= {{2{p0a_r[63]}}, p0a_r} + {{2{p0b_r[63]}}, p0b_r}
            + {{14{xw_r[47]}}, xw_r, 4'b0};
      g1_r <= {{2{p1a_r[63]}}, p1a_r} + {{2{p1b_r[63]}}, p1b_r}
            + {{14{yw_r[47]}}, yw_r, 4'b0};
      g2_r <= {{2{p2a_r[63]}}, p2a_r} + {{2{p2b_r[63]}}, p2b_r}
            + {{14{ww_r[47]}}, ww_r, 4'b0};
      x2_r <= x1_r;
      y2_r <= y1_r;
    end
  end

  // ---------------- stage 3: P'G terms and gradient magnitudes -------------
  logic               v3_r;
  logic signed [81:0] nx_r, ny_r;
  logic signed [65:0] g2b_r;
  logic [65:0]        a0_r, a1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r  <= x2_r * g0_r;
      ny_r  <= y2_r * g1_r;
      g2b_r <= g2_r;
      a0_r  <= g0_r[65] ? 66'(-g0_r) : g0_r;
      a1_r  <= g1_r[65] ? 66'(-g1_r) : g1_r;
    end
  end

  // ---------------- stage 4: N sum and squared-gradient partials -----------
  // |G|^2 = hh<<66 + 2*hl<<33 + ll with 33-bit halves
  logic               v4_r;
  logic signed [81:0] n_r;
  logic [65:0]        hh0_r, hl0_r, ll0_r, hh1_r, hl1_r, ll1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= nx_r + ny_r + {{12{g2b_r[65]}}, g2b_r, 4'b0};
      hh0_r <= a0_r[65:33] * a0_r[65:33];
      hl0_r <= a0_r[65:33] * a0_r[32:0];
      ll0_r <= a0_r[32:0]  * a0_r[32:0];
      hh1_r <= a1_r[65:33] * a1_r[65:33];
      hl1_r <= a1_r[65:33] * a1_r[32:0];
      ll1_r <= a1_r[32:0]  * a1_r[32:0];
    end
  end

  // ---------------- stage 5: S, |N| and sign -------------------------------
  logic [131:0] s_nxt;
  assign s_nxt = {hh0_r, 66'd0} + {32'd0, hl0_r, 34'd0} + {66'd0, ll0_r}
               + {hh1_r, 66'd0} + {32'd0, hl1_r, 34'd0} + {66'd0, ll1_r};

  // ---------------- square root: one root bit per stage --------------------
  logic        sq_v_r   [0:SQ_STEPS];
  sq_t         sq_r     [0:SQ_STEPS];
  logic [81:0] sq_nab_r [0:SQ_STEPS];
  logic        sq_neg_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].s     <= s_nxt[129:0];
      sq_r[0].rem   <= '0;
      sq_r[0].root  <= '0;
      sq_nab_r[0]   <= n_r[81] ? 82'(-n_r) : n_r;
      sq_neg_r[0]   <= mode_r & n_r[81];
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1]     <= sq_step(sq_r[k]);
        sq_nab_r[k+1] <= sq_nab_r[k];
        sq_neg_r[k+1] <= sq_neg_r[k];
      end
    end
  end

  // ---------------- divide setup: floor R, saturation pre-check ------------
  logic [63:0] r_nxt;
  logic [92:0] m_nxt;
  assign r_nxt = (sq_r[SQ_STEPS].root[63:0] == 64'd0) ? 64'd1
                                                      : sq_r[SQ_STEPS].root[63:0];
  assign m_nxt = {sq_nab_r[SQ_STEPS], 11'd0};

  logic        dv_v_r   [0:DIV_STEPS];
  dv_t         dv_r     [0:DIV_STEPS];
  logic [63:0] dv_den_r [0:DIV_STEPS];
  logic        dv_neg_r [0:DIV_STEPS];
  logic        dv_sat_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].mb  <= m_nxt[32:0];
      dv_r[0].rem <= {4'd0, m_nxt[92:33]};
      dv_r[0].q   <= '0;
      dv_den_r[0] <= r_nxt;
      dv_neg_r[0] <= sq_neg_r[SQ_STEPS];
      // quotient would need more than 33 bits
      dv_sat_r[0] <= {4'd0, m_nxt} >= {r_nxt, 33'd0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1]     <= dv_step(dv_r[k], dv_den_r[k]);
        dv_den_r[k+1] <= dv_den_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_sat_r[k+1] <= dv_sat_r[k];
      end
    end
  end

  // ---------------- output: clip and sign ----------------------------------
  logic        neg_f;
  logic [32:0] mag_f;
  logic        clip_nxt;
  logic [31:0] mag_nxt;
  assign neg_f    = dv_neg_r[DIV_STEPS];
  assign mag_f    = dv_r[DIV_STEPS].q;
  assign clip_nxt = dv_sat_r[DIV_STEPS]
                  | (neg_f ? (mag_f > 33'h0_8000_0000) : (mag_f > 33'h0_7FFF_FFFF));
  assign mag_nxt  = clip_nxt ? (neg_f ? 32'h8000_0000 : 32'h7FFF_FFFF) : mag_f[31:0];

  dist_t dist_r;
  logic  sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= neg_f ? dist_t'(-mag_nxt) : dist_t'(mag_nxt);
      sat_r  <= clip_nxt;
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      sq_v_r[0]   <= 1'b0;
      dv_v_r[0]   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      sq_v_r[0]   <= v4_r;
      dv_v_r[0]   <= sq_v_r[SQ_STEPS];
      out_valid_r <= dv_v_r[DIV_STEPS];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.saturated = sat_r;

  // ---------------- checks -------------------------------------------------
  // a clipped result sits exactly on a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> (dist_r == 32'sh7FFF_FFFF || dist_r == 32'sh8000_0000))
    else $error("saturated result not at a range limit");

  // magnitude mode never yields a negative distance
  a_mag_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !mode_r) |-> !dist_r[31])
    else $error("negative distance in magnitude mode");

endmodule
`default_nettype wire
